// File: rtl/core/ssm_pkg.sv
// package for safety_status_merge: item types, codes, register indexes and merge helpers
package ssm_pkg;

    localparam int MODE_W     = 3;
    localparam int BUTTON_W   = 2;
    localparam int BEHAVIOR_W = 3;
    localparam int WORD_W     = 64;
    localparam int CNT_W      = 2;
    localparam int CFG_ADDR_W = 3;

    localparam int MAX_PATTERNS_DEFAULT = 3;

    localparam logic CMD_FOLD   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [MODE_W-1:0]     MODE_UNKNOWN     = 3'd0;
    localparam logic [MODE_W-1:0]     MODE_LAST        = 3'd5;
    localparam logic [BEHAVIOR_W-1:0] BEHAVIOR_UNKNOWN = 3'd0;
    localparam logic [BEHAVIOR_W-1:0] BEHAVIOR_PAUSE   = 3'd2;
    localparam logic [BEHAVIOR_W-1:0] BEHAVIOR_LAST    = 3'd5;

    localparam logic [BUTTON_W-1:0] BUTTON_UNKNOWN    = 2'd0;
    localparam logic [BUTTON_W-1:0] BUTTON_NA         = 2'd1;
    localparam logic [BUTTON_W-1:0] BUTTON_DISENGAGED = 2'd2;
    localparam logic [BUTTON_W-1:0] BUTTON_ENGAGED    = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_PAUSE_ENABLE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_COUNT = 3'd1;
    localparam int                    REG_PATTERN_BASE  = 2;

    typedef struct packed {
        logic                  cmd;
        logic [MODE_W-1:0]     in_mode;
        logic [BUTTON_W-1:0]   in_estop;
        logic [BUTTON_W-1:0]   in_enable;
        logic [BEHAVIOR_W-1:0] in_behavior;
        logic [WORD_W-1:0]     digital_inputs;
    } in_item_t;

    typedef struct packed {
        logic [MODE_W-1:0]     out_mode;
        logic [BUTTON_W-1:0]   out_estop;
        logic [BUTTON_W-1:0]   out_enable;
        logic [BEHAVIOR_W-1:0] out_behavior;
        logic                  pause_signal_active;
    } out_item_t;

    // stage controls from the handshake logic to the merge unit
    typedef struct packed {
        logic fold;
        logic finish;
    } stage_ctl_t;

    function automatic logic [MODE_W-1:0] clip_mode(input logic [MODE_W-1:0] v);
        clip_mode = (v > MODE_LAST) ? MODE_UNKNOWN : v;
    endfunction

    function automatic logic [BEHAVIOR_W-1:0] clip_behavior(input logic [BEHAVIOR_W-1:0] v);
        clip_behavior = (v > BEHAVIOR_LAST) ? BEHAVIOR_UNKNOWN : v;
    endfunction

    // disengaged outranks engaged
    function automatic logic [BUTTON_W-1:0] enable_rank(input logic [BUTTON_W-1:0] code);
        case (code)
            BUTTON_DISENGAGED: enable_rank = 2'd3;
            BUTTON_ENGAGED:    enable_rank = 2'd2;
            default:           enable_rank = code;
        endcase
    endfunction

endpackage

// File: rtl/core/ssm_merge.sv
// severity accumulators and pause pattern match for safety_status_merge
module ssm_merge #(
    parameter int MAX_PATTERNS = ssm_pkg::MAX_PATTERNS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ssm_pkg::stage_ctl_t                  ctl,
    input  ssm_pkg::in_item_t                    item,
    input  logic                                 pause_enable,
    input  logic [ssm_pkg::CNT_W-1:0]            pattern_count,
    input  logic [MAX_PATTERNS-1:0][ssm_pkg::WORD_W-1:0] pattern_mask,
    input  logic [MAX_PATTERNS-1:0][ssm_pkg::WORD_W-1:0] pattern_value,
    output ssm_pkg::out_item_t                   result
);

    logic [ssm_pkg::MODE_W-1:0]     mode_acc_reg,     mode_acc_next;
    logic [ssm_pkg::BUTTON_W-1:0]   estop_acc_reg,    estop_acc_next;
    logic [ssm_pkg::BUTTON_W-1:0]   enable_acc_reg,   enable_acc_next;
    logic [ssm_pkg::BEHAVIOR_W-1:0] behavior_acc_reg, behavior_acc_next;

    logic [ssm_pkg::MODE_W-1:0]     mode_in;
    logic [ssm_pkg::BEHAVIOR_W-1:0] behavior_in;
    logic [MAX_PATTERNS-1:0]        hit;
    logic                           active;

    assign mode_in     = ssm_pkg::clip_mode(item.in_mode);
    assign behavior_in = ssm_pkg::clip_behavior(item.in_behavior);

    always_comb begin
        mode_acc_next     = mode_acc_reg;
        estop_acc_next    = estop_acc_reg;
        enable_acc_next   = enable_acc_reg;
        behavior_acc_next = behavior_acc_reg;
        if (ctl.finish) begin
            mode_acc_next     = ssm_pkg::MODE_UNKNOWN;
            estop_acc_next    = ssm_pkg::BUTTON_UNKNOWN;
            enable_acc_next   = ssm_pkg::BUTTON_UNKNOWN;
            behavior_acc_next = ssm_pkg::BEHAVIOR_UNKNOWN;
        end else if (ctl.fold) begin
            if (mode_in > mode_acc_reg) begin
                mode_acc_next = mode_in;
            end
            if (item.in_estop > estop_acc_reg) begin
                estop_acc_next = item.in_estop;
            end
            if (ssm_pkg::enable_rank(item.in_enable) > ssm_pkg::enable_rank(enable_acc_reg)) begin
                enable_acc_next = item.in_enable;
            end
            if (behavior_in > behavior_acc_reg) begin
                behavior_acc_next = behavior_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_acc_reg     <= ssm_pkg::MODE_UNKNOWN;
            estop_acc_reg    <= ssm_pkg::BUTTON_UNKNOWN;
            enable_acc_reg   <= ssm_pkg::BUTTON_UNKNOWN;
            behavior_acc_reg <= ssm_pkg::BEHAVIOR_UNKNOWN;
        end else begin
            mode_acc_reg     <= mode_acc_next;
            estop_acc_reg    <= estop_acc_next;
            enable_acc_reg   <= enable_acc_next;
            behavior_acc_reg <= behavior_acc_next;
        end
    end

    // patterns beyond the configured count never match
    for (genvar i = 0; i < MAX_PATTERNS; i++) begin : g_match
        assign hit[i] = (ssm_pkg::CNT_W'(i) < pattern_count)
                        && ((item.digital_inputs & pattern_mask[i]) == pattern_value[i]);
    end

    assign active = pause_enable && (|hit);

    always_comb begin
        result.out_mode            = mode_acc_reg;
        result.out_estop           = estop_acc_reg;
        result.out_enable          = enable_acc_reg;
        result.out_behavior        = behavior_acc_reg;
        result.pause_signal_active = active;
        if (active && (behavior_acc_reg < ssm_pkg::BEHAVIOR_PAUSE)) begin
            result.out_behavior = ssm_pkg::BEHAVIOR_PAUSE;
        end
    end

    a_clear_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.finish |=> (mode_acc_reg == ssm_pkg::MODE_UNKNOWN)
                    && (estop_acc_reg == ssm_pkg::BUTTON_UNKNOWN)
                    && (enable_acc_reg == ssm_pkg::BUTTON_UNKNOWN)
                    && (behavior_acc_reg == ssm_pkg::BEHAVIOR_UNKNOWN))
        else $error("accumulators not cleared after finish");

    a_acc_codes_defined: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_acc_reg <= ssm_pkg::MODE_LAST) && (behavior_acc_reg <= ssm_pkg::BEHAVIOR_LAST))
        else $error("accumulator holds an undefined code");

    a_idle_holds_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ctl.fold && !ctl.finish) |=> $stable(mode_acc_reg) && $stable(estop_acc_reg)
                                    && $stable(enable_acc_reg) && $stable(behavior_acc_reg))
        else $error("accumulator changed without a transaction");

endmodule

// File: rtl/core/safety_status_merge.sv
// Merges per-cycle safety module reports into one status. Every accepted transaction
// passes an input register and, for a finish, a result register, so the block takes one
// transaction per clock: a report fold never stalls the stage, and a finish stalls it, and
// any transaction offered behind it, only while the result register still holds an
// untaken result. Configuration writes are applied in the cycle after the write enable
// and should only be made while no transaction is in flight.
module safety_status_merge #(
    parameter int MAX_PATTERNS = ssm_pkg::MAX_PATTERNS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ssm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ssm_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ssm_pkg::in_item_t             s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ssm_pkg::out_item_t            m_item
);

    logic                                 pause_enable_reg;
    logic [ssm_pkg::CNT_W-1:0]            pattern_count_reg;
    logic [MAX_PATTERNS-1:0][ssm_pkg::WORD_W-1:0] pattern_mask_reg;
    logic [MAX_PATTERNS-1:0][ssm_pkg::WORD_W-1:0] pattern_value_reg;

    logic                in_vld_reg, in_vld_next;
    ssm_pkg::in_item_t   in_item_reg;
    logic                out_vld_reg, out_vld_next;
    ssm_pkg::out_item_t  out_item_reg;
    ssm_pkg::out_item_t  result;
    ssm_pkg::stage_ctl_t ctl;
    logic                out_free;
    logic                stage_go;
    logic                s_fire;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pause_enable_reg  <= 1'b0;
            pattern_count_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_addr == ssm_pkg::REG_PAUSE_ENABLE) begin
                pause_enable_reg <= cfg_wdata[0];
            end
            if (cfg_addr == ssm_pkg::REG_PATTERN_COUNT) begin
                pattern_count_reg <= cfg_wdata[ssm_pkg::CNT_W-1:0];
            end
        end
    end

    for (genvar i = 0; i < MAX_PATTERNS; i++) begin : g_pattern
        localparam logic [ssm_pkg::CFG_ADDR_W-1:0] MaskAddr =
            ssm_pkg::CFG_ADDR_W'(ssm_pkg::REG_PATTERN_BASE + 2 * i);
        localparam logic [ssm_pkg::CFG_ADDR_W-1:0] ValueAddr =
            ssm_pkg::CFG_ADDR_W'(ssm_pkg::REG_PATTERN_BASE + 2 * i + 1);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pattern_mask_reg[i]  <= '0;
                pattern_value_reg[i] <= '0;
            end else if (cfg_we) begin
                if (cfg_addr == MaskAddr) begin
                    pattern_mask_reg[i] <= cfg_wdata;
                end
                if (cfg_addr == ValueAddr) begin
                    pattern_value_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // handshake
    assign out_free = !out_vld_reg || m_ready;
    assign stage_go = in_vld_reg && ((in_item_reg.cmd == ssm_pkg::CMD_FOLD) || out_free);
    assign s_ready  = !in_vld_reg || stage_go;
    assign s_fire   = s_valid && s_ready;

    assign ctl.fold   = stage_go && (in_item_reg.cmd == ssm_pkg::CMD_FOLD);
    assign ctl.finish = stage_go && (in_item_reg.cmd == ssm_pkg::CMD_FINISH);

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (stage_go) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (ctl.finish) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (ctl.finish) begin
            out_item_reg <= result;
        end
    end

    ssm_merge #(
        .MAX_PATTERNS (MAX_PATTERNS)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .item          (in_item_reg),
        .pause_enable  (pause_enable_reg),
        .pattern_count (pattern_count_reg),
        .pattern_mask  (pattern_mask_reg),
        .pattern_value (pattern_value_reg),
        .result        (result)
    );

    assign m_valid = out_vld_reg;
    assign m_item  = out_item_reg;

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(in_vld_reg && (in_item_reg.cmd == ssm_pkg::CMD_FINISH)))
        else $error("result appeared without a finish transaction");

    a_pause_in_behavior: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_item_reg.pause_signal_active)
            |-> (out_item_reg.out_behavior >= ssm_pkg::BEHAVIOR_PAUSE))
        else $error("pause match not merged into behavior");

    a_finish_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && (in_item_reg.cmd == ssm_pkg::CMD_FINISH) && !out_free)
            |=> in_vld_reg && (in_item_reg.cmd == ssm_pkg::CMD_FINISH))
        else $error("stalled finish transaction lost");

    a_fold_never_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && (in_item_reg.cmd == ssm_pkg::CMD_FOLD)) |-> s_ready)
        else $error("fold transaction stalled the input");

endmodule

// File: tb/tb_safety_status_merge.sv
// testbench for safety_status_merge: random and directed reports checked against a merge predictor
`timescale 1ns / 1ps

module tb_safety_status_merge;

    localparam logic [ssm_pkg::MODE_W-1:0]     MODE_AUTOMATIC     = 3'd1;
    localparam logic [ssm_pkg::MODE_W-1:0]     MODE_PENDANT1      = 3'd2;
    localparam logic [ssm_pkg::MODE_W-1:0]     MODE_PENDANT2      = 3'd3;
    localparam logic [ssm_pkg::MODE_W-1:0]     MODE_CONFIGURATION = 3'd4;
    localparam logic [ssm_pkg::BEHAVIOR_W-1:0] BEHAVIOR_NORMAL    = 3'd1;
    localparam logic [ssm_pkg::BEHAVIOR_W-1:0] BEHAVIOR_STOP2     = 3'd3;
    localparam logic [ssm_pkg::BEHAVIOR_W-1:0] BEHAVIOR_STOP1     = 3'd4;
    localparam logic [2:0]                     CODE_UNDEF_LO      = 3'd6;
    localparam logic [2:0]                     CODE_UNDEF_HI      = 3'd7;
    localparam int                             PATTERN_SLOTS      = 3;
    localparam int                             ITEMS_PER_SEGMENT  = 280;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [ssm_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [ssm_pkg::WORD_W-1:0]     cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    ssm_pkg::in_item_t              s_item    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    ssm_pkg::out_item_t             m_item;

    safety_status_merge dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    ssm_pkg::in_item_t  pending_reports [$];
    ssm_pkg::out_item_t expected_status [$];
    ssm_pkg::out_item_t oldest_status;
    int                 failures           = 0;
    int                 sender_idle_pct    = 19;
    int                 receiver_stall_pct = 62;

    // predictor state
    logic                           pause_en      = 1'b0;
    logic [ssm_pkg::CNT_W-1:0]      pattern_count = '0;
    logic [ssm_pkg::WORD_W-1:0]     pat_mask  [PATTERN_SLOTS] = '{default: '0};
    logic [ssm_pkg::WORD_W-1:0]     pat_value [PATTERN_SLOTS] = '{default: '0};
    logic [ssm_pkg::MODE_W-1:0]     acc_mode      = ssm_pkg::MODE_UNKNOWN;
    logic [ssm_pkg::BUTTON_W-1:0]   acc_estop     = ssm_pkg::BUTTON_UNKNOWN;
    logic [ssm_pkg::BUTTON_W-1:0]   acc_enable    = ssm_pkg::BUTTON_UNKNOWN;
    logic [ssm_pkg::BEHAVIOR_W-1:0] acc_behavior  = ssm_pkg::BEHAVIOR_UNKNOWN;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [ssm_pkg::WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic ssm_pkg::in_item_t make_item(input logic cmd,
                                                    input logic [ssm_pkg::MODE_W-1:0] mode,
                                                    input logic [ssm_pkg::BUTTON_W-1:0] estop,
                                                    input logic [ssm_pkg::BUTTON_W-1:0] enable,
                                                    input logic [ssm_pkg::BEHAVIOR_W-1:0] behavior,
                                                    input logic [ssm_pkg::WORD_W-1:0] word);
        ssm_pkg::in_item_t it;
        it.cmd            = cmd;
        it.in_mode        = mode;
        it.in_estop       = estop;
        it.in_enable      = enable;
        it.in_behavior    = behavior;
        it.digital_inputs = word;
        return it;
    endfunction

    function automatic void queue_report(input ssm_pkg::in_item_t it);
        pending_reports.insert(pending_reports.size(), it);
    endfunction

    // disengaged outranks engaged
    function automatic int enable_severity(input logic [ssm_pkg::BUTTON_W-1:0] code);
        case (code)
            ssm_pkg::BUTTON_DISENGAGED: return 3;
            ssm_pkg::BUTTON_ENGAGED:    return 2;
            ssm_pkg::BUTTON_NA:         return 1;
            default:                    return 0;
        endcase
    endfunction

    function automatic void merge_transaction(input ssm_pkg::in_item_t it);
        ssm_pkg::out_item_t             status;
        logic [ssm_pkg::MODE_W-1:0]     mode;
        logic [ssm_pkg::BEHAVIOR_W-1:0] behavior;
        logic                           hit;
        if (it.cmd == ssm_pkg::CMD_FOLD) begin
            mode     = (it.in_mode > ssm_pkg::MODE_LAST) ? ssm_pkg::MODE_UNKNOWN : it.in_mode;
            behavior = (it.in_behavior > ssm_pkg::BEHAVIOR_LAST) ?
                       ssm_pkg::BEHAVIOR_UNKNOWN : it.in_behavior;
            if (mode > acc_mode) acc_mode = mode;
            if (it.in_estop > acc_estop) acc_estop = it.in_estop;
            if (enable_severity(it.in_enable) > enable_severity(acc_enable)) begin
                acc_enable = it.in_enable;
            end
            if (behavior > acc_behavior) acc_behavior = behavior;
        end else begin
            hit = 1'b0;
            if (pause_en) begin
                for (int i = 0; i < PATTERN_SLOTS; i++) begin
                    if (i < pattern_count && i < ssm_pkg::MAX_PATTERNS_DEFAULT &&
                        (it.digital_inputs & pat_mask[i]) == pat_value[i]) begin
                        hit = 1'b1;
                    end
                end
            end
            status.out_mode            = acc_mode;
            status.out_estop           = acc_estop;
            status.out_enable          = acc_enable;
            status.out_behavior        = (hit && acc_behavior < ssm_pkg::BEHAVIOR_PAUSE) ?
                                         ssm_pkg::BEHAVIOR_PAUSE : acc_behavior;
            status.pause_signal_active = hit;
            expected_status.insert(expected_status.size(), status);
            acc_mode     = ssm_pkg::MODE_UNKNOWN;
            acc_estop    = ssm_pkg::BUTTON_UNKNOWN;
            acc_enable   = ssm_pkg::BUTTON_UNKNOWN;
            acc_behavior = ssm_pkg::BEHAVIOR_UNKNOWN;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                merge_transaction(s_item);
            end
            if (!s_valid || s_ready) begin
                if (pending_reports.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item  <= pending_reports.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, m_item);
                    failures++;
                end else begin
                    oldest_status = expected_status.pop_front();
                    if (m_item.out_mode !== oldest_status.out_mode ||
                        m_item.out_estop !== oldest_status.out_estop ||
                        m_item.out_enable !== oldest_status.out_enable ||
                        m_item.out_behavior !== oldest_status.out_behavior ||
                        m_item.pause_signal_active !== oldest_status.pause_signal_active) begin
                        $display({"%0t: mismatch mode/estop/enable/behavior/pause",
                                  " expected %0d %0d %0d %0d %0d",
                                  " actual %0d %0d %0d %0d %0d"},
                                 $time, oldest_status.out_mode, oldest_status.out_estop,
                                 oldest_status.out_enable, oldest_status.out_behavior,
                                 oldest_status.pause_signal_active, m_item.out_mode,
                                 m_item.out_estop, m_item.out_enable, m_item.out_behavior,
                                 m_item.pause_signal_active);
                        failures++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic wait_drained();
        while (pending_reports.size() > 0 || s_valid || expected_status.size() > 0) begin
            @(negedge aclk);
        end
        // a trailing fold may still sit in the input register
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ssm_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [ssm_pkg::WORD_W-1:0] data);
        int offset;
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        if (addr == ssm_pkg::REG_PAUSE_ENABLE) begin
            pause_en = data[0];
        end else if (addr == ssm_pkg::REG_PATTERN_COUNT) begin
            pattern_count = data[ssm_pkg::CNT_W-1:0];
        end else begin
            offset = int'(addr) - ssm_pkg::REG_PATTERN_BASE;
            if (offset % 2 == 0) begin
                pat_mask[offset / 2] = data;
            end else begin
                pat_value[offset / 2] = data;
            end
        end
    endtask

    task automatic program_pause(input logic pe, input logic [ssm_pkg::CNT_W-1:0] cnt,
                                 input logic [ssm_pkg::WORD_W-1:0] m0,
                                 input logic [ssm_pkg::WORD_W-1:0] v0,
                                 input logic [ssm_pkg::WORD_W-1:0] m1,
                                 input logic [ssm_pkg::WORD_W-1:0] v1,
                                 input logic [ssm_pkg::WORD_W-1:0] m2,
                                 input logic [ssm_pkg::WORD_W-1:0] v2);
        logic [ssm_pkg::WORD_W-1:0] w;
        // upper bits carry noise that the block must drop
        w = rand_word();
        w[0] = pe;
        write_reg(ssm_pkg::REG_PAUSE_ENABLE, w);
        w = rand_word();
        w[ssm_pkg::CNT_W-1:0] = cnt;
        write_reg(ssm_pkg::REG_PATTERN_COUNT, w);
        write_reg(ssm_pkg::CFG_ADDR_W'(ssm_pkg::REG_PATTERN_BASE),     m0);
        write_reg(ssm_pkg::CFG_ADDR_W'(ssm_pkg::REG_PATTERN_BASE + 1), v0);
        write_reg(ssm_pkg::CFG_ADDR_W'(ssm_pkg::REG_PATTERN_BASE + 2), m1);
        write_reg(ssm_pkg::CFG_ADDR_W'(ssm_pkg::REG_PATTERN_BASE + 3), v1);
        write_reg(ssm_pkg::CFG_ADDR_W'(ssm_pkg::REG_PATTERN_BASE + 4), m2);
        write_reg(ssm_pkg::CFG_ADDR_W'(ssm_pkg::REG_PATTERN_BASE + 5), v2);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [ssm_pkg::WORD_W-1:0] rmask  [PATTERN_SLOTS];
        logic [ssm_pkg::WORD_W-1:0] rvalue [PATTERN_SLOTS];
        logic [ssm_pkg::WORD_W-1:0] word;
        logic                       pe;
        logic [ssm_pkg::CNT_W-1:0]  cnt;
        int                         queued;
        int                         folds;
        int                         slot;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: pause injection off, no patterns
        queue_report(make_item(ssm_pkg::CMD_FINISH, CODE_UNDEF_HI, ssm_pkg::BUTTON_ENGAGED,
                               ssm_pkg::BUTTON_ENGAGED, CODE_UNDEF_HI, '1));
        queue_report(make_item(ssm_pkg::CMD_FOLD, ssm_pkg::MODE_LAST, ssm_pkg::BUTTON_ENGAGED,
                               ssm_pkg::BUTTON_ENGAGED, ssm_pkg::BEHAVIOR_LAST, '1));
        queue_report(make_item(ssm_pkg::CMD_FOLD, CODE_UNDEF_HI, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BUTTON_DISENGAGED, CODE_UNDEF_LO, '0));
        queue_report(make_item(ssm_pkg::CMD_FOLD, ssm_pkg::MODE_UNKNOWN, ssm_pkg::BUTTON_NA,
                               ssm_pkg::BUTTON_NA, ssm_pkg::BEHAVIOR_UNKNOWN, '1));
        queue_report(make_item(ssm_pkg::CMD_FINISH, ssm_pkg::MODE_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BEHAVIOR_UNKNOWN, '0));
        queue_report(make_item(ssm_pkg::CMD_FOLD, CODE_UNDEF_LO, ssm_pkg::BUTTON_NA,
                               ssm_pkg::BUTTON_NA, CODE_UNDEF_HI, '0));
        queue_report(make_item(ssm_pkg::CMD_FOLD, ssm_pkg::MODE_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, ssm_pkg::BEHAVIOR_UNKNOWN, '0));
        queue_report(make_item(ssm_pkg::CMD_FINISH, ssm_pkg::MODE_LAST, ssm_pkg::BUTTON_NA,
                               ssm_pkg::BUTTON_DISENGAGED, ssm_pkg::BEHAVIOR_LAST, '0));
        queue_report(make_item(ssm_pkg::CMD_FOLD, MODE_AUTOMATIC, ssm_pkg::BUTTON_DISENGAGED,
                               ssm_pkg::BUTTON_DISENGAGED, BEHAVIOR_NORMAL, '0));
        queue_report(make_item(ssm_pkg::CMD_FOLD, MODE_PENDANT1, ssm_pkg::BUTTON_NA,
                               ssm_pkg::BUTTON_ENGAGED, ssm_pkg::BEHAVIOR_PAUSE, '0));
        queue_report(make_item(ssm_pkg::CMD_FINISH, ssm_pkg::MODE_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BEHAVIOR_UNKNOWN, '1));
        queue_report(make_item(ssm_pkg::CMD_FOLD, MODE_PENDANT2, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BUTTON_ENGAGED, BEHAVIOR_STOP2, '0));
        queue_report(make_item(ssm_pkg::CMD_FOLD, MODE_CONFIGURATION, ssm_pkg::BUTTON_NA,
                               ssm_pkg::BUTTON_NA, BEHAVIOR_STOP1, '0));
        queue_report(make_item(ssm_pkg::CMD_FOLD, MODE_AUTOMATIC, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, BEHAVIOR_NORMAL, '0));
        queue_report(make_item(ssm_pkg::CMD_FINISH, ssm_pkg::MODE_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BEHAVIOR_UNKNOWN, '0));
        wait_drained();

        // injection on but no pattern in use
        program_pause(1'b1, 2'd0, '1, '0, '1, '1, '0, '0);
        queue_report(make_item(ssm_pkg::CMD_FINISH, ssm_pkg::MODE_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BEHAVIOR_UNKNOWN, '0));
        wait_drained();

        // first pattern matches only the all-zero word
        program_pause(1'b1, 2'd1, '1, '0, '1, '1, '0, '0);
        queue_report(make_item(ssm_pkg::CMD_FOLD, ssm_pkg::MODE_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, BEHAVIOR_NORMAL, '0));
        queue_report(make_item(ssm_pkg::CMD_FINISH, ssm_pkg::MODE_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BEHAVIOR_UNKNOWN, '0));
        queue_report(make_item(ssm_pkg::CMD_FOLD, ssm_pkg::MODE_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, ssm_pkg::BEHAVIOR_LAST, '0));
        queue_report(make_item(ssm_pkg::CMD_FINISH, ssm_pkg::MODE_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BEHAVIOR_UNKNOWN, '0));
        queue_report(make_item(ssm_pkg::CMD_FINISH, ssm_pkg::MODE_UNKNOWN,
                               ssm_pkg::BUTTON_UNKNOWN, ssm_pkg::BUTTON_UNKNOWN,
                               ssm_pkg::BEHAVIOR_UNKNOWN, 64'd1));
        wait_drained();

        for (int seg = 0; seg < 6; seg++) begin
            sender_idle_pct    = (seg < 2) ? 19 : (seg < 4) ? 62 : 0;
            receiver_stall_pct = (seg < 2) ? 62 : (seg < 4) ? 19 : 0;
            pe  = (seg != 4);
            cnt = (seg < 4) ? ssm_pkg::CNT_W'(seg) : (seg == 4) ? 2'd3 : 2'd2;
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                case ($urandom_range(3))
                    0:       rmask[i] = '0;
                    1:       rmask[i] = '1;
                    default: rmask[i] = rand_word();
                endcase
                rvalue[i] = ($urandom_range(3) == 0) ? rand_word() : (rand_word() & rmask[i]);
            end
            program_pause(pe, cnt, rmask[0], rvalue[0], rmask[1], rvalue[1],
                          rmask[2], rvalue[2]);

            queued = 0;
            while (queued < ITEMS_PER_SEGMENT) begin
                folds = $urandom_range(6);
                for (int f = 0; f < folds; f++) begin
                    queue_report(make_item(ssm_pkg::CMD_FOLD, ssm_pkg::MODE_W'($urandom),
                                           ssm_pkg::BUTTON_W'($urandom),
                                           ssm_pkg::BUTTON_W'($urandom),
                                           ssm_pkg::BEHAVIOR_W'($urandom), rand_word()));
                end
                slot = $urandom_range(PATTERN_SLOTS - 1);
                case ($urandom_range(9))
                    0:          word = '0;
                    1:          word = '1;
                    2, 3, 4, 5: word = (rand_word() & ~pat_mask[slot]) |
                                       (pat_value[slot] & pat_mask[slot]);
                    default:    word = rand_word();
                endcase
                queue_report(make_item(ssm_pkg::CMD_FINISH, ssm_pkg::MODE_W'($urandom),
                                       ssm_pkg::BUTTON_W'($urandom),
                                       ssm_pkg::BUTTON_W'($urandom),
                                       ssm_pkg::BEHAVIOR_W'($urandom), word));
                queued += folds + 1;
            end
            wait_drained();
        end

        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
